/* hw/rtl/ph_pc_pkg.sv */
// ph_pc_pkg: widths, constants, register indexes and beat structs of the pH probe conditioner
// no dependencies; used by ph_pc_div and ph_probe_conditioner_core
package ph_pc_pkg;

  localparam int SAMPLES_DEFAULT = 64;

  localparam int SUM_W     = 18;
  localparam int TEMP_W    = 12;
  localparam int PIN_W     = 20;
  localparam int PROBE_W   = 21;
  localparam int CNT_W     = 16;
  localparam int PH_W      = 14;
  localparam int SLOPE_W   = 17;
  localparam int OFFMV_W   = 21;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 3;
  localparam int ABSK_W    = 20;
  localparam int TK_W      = 21;
  localparam int PNUM_W    = 31;

  // serial divider sizes
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 26;
  localparam int DIV_CW = 6;

  // quotient bits per operation
  localparam int AVG_BITS   = SUM_W + 8;
  localparam int FLT_BITS   = 21;
  localparam int SLOPE_BITS = 40;
  localparam int PH_BITS    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_POINT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MV  = 3'd4;

  localparam logic signed [SLOPE_W-1:0] SLOPE_RST     = -17'sd15145;
  localparam logic [PH_W-1:0]           OFFSET_PH_RST = 14'd7000;
  localparam logic [OFFMV_W-1:0]        OFFSET_MV_RST = 21'd640000;

  localparam logic [PIN_W-1:0]  PIN_MAX = 20'hFFFFF;
  localparam logic [PIN_W-1:0]  CLIP_Q8 = 20'd780800;
  localparam logic [PH_W-1:0]   PH_MAX  = 14'd14000;
  localparam logic [9:0]        MILLI   = 10'd1000;

  // filter: alpha 1/10, ties toward +inf
  localparam logic [DIV_DW-1:0] FLT_DEN     = 26'd10;
  localparam logic [2:0]        FLT_RND_POS = 3'd5;
  localparam logic [2:0]        FLT_RND_NEG = 3'd4;

  // nominal slope: 59.16 mV/pH * 256 * (T + 273.15) / 298.15, T in 1/16 degree
  localparam logic signed [TK_W-1:0] TEMP_SCALE  = 21'sd100;
  localparam logic signed [TK_W-1:0] ABS_ZERO    = 21'sd437040;
  localparam logic [DIV_NW-1:0]      NOM_SCALE   = 40'd1514496;
  localparam logic [DIV_DW-1:0]      SLOPE_DEN   = 26'd47704000;
  localparam logic [DIV_NW-1:0]      SLOPE_HALF  = 40'd23852000;

  typedef struct packed {
    logic [SUM_W-1:0]         adc_sum_mv;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] temp_sixteenths;
  } sample_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_mv_q8;
    logic [PROBE_W-1:0] probe_mv_q8;
    logic               clipped;
    logic [CNT_W-1:0]   clip_count;
    logic [PH_W-1:0]    ph_milli;
    logic               ph_valid;
    logic               temp_compensated;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/ph_pc_chan.sv */
// ph_pc_chan: valid/ready channel carrying one payload beat
// no dependencies; payload type is set per instance
interface ph_pc_chan #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

/* hw/rtl/ph_pc_div.sv */
// ph_pc_div: bit-serial restoring divider, one quotient bit per cycle
// depends on ph_pc_pkg; numerator arrives left-aligned to nbits
module ph_pc_div
  import ph_pc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] count;
  logic [DIV_NW-1:0] n;
  logic [DIV_DW-1:0] r;
  logic [DIV_DW-1:0] d;

  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              ge;
  logic [DIV_DW-1:0] r_next;
  logic [DIV_NW-1:0] n_next;

  assign rem_sh  = {r, n[DIV_NW-1]};
  assign rem_sub = rem_sh - {1'b0, d};
  assign ge      = rem_sh >= {1'b0, d};
  assign r_next  = ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
  assign n_next  = {n[DIV_NW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == DIV_CW'(1));
      if (req.start) begin
        busy  <= 1'b1;
        count <= req.nbits;
      end else if (busy) begin
        count <= count - DIV_CW'(1);
        if (count == DIV_CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n <= req.num;
      r <= '0;
      d <= req.den;
    end else if (busy) begin
      n <= n_next;
      r <= r_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = n;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");
  a_count_live: assert property (@(posedge clk) disable iff (rst) busy |-> count != '0)
    else $error("divider busy with zero count");
`endif

endmodule

/* hw/rtl/ph_probe_conditioner_core.sv */
// pH probe conditioner top: averaging, ema filter, clip count, Nernst slope and pH division
// usage: samples sink beats carry an adc sum and temperature; results source beats carry
// filtered voltages, clip status and pH. configuration is a plain write port, one register
// per index (0 calibrated, 1 two_point_mode, 2 slope_q8, 3 offset_ph_milli, 4 offset_mv_q8);
// other indexes are dropped. write only while no beat is in flight.
// one beat is worked at a time; samples.ready is high only while the core is idle.
// the time from sample accept to result valid is set by the
// bit-serial divider, one quotient bit per cycle, shared by up to four divisions:
// average (26 bits), filter step (21 bits, not on the first beat after reset),
// temperature slope (40 bits, only when compensating) and pH (32 bits, only when
// calibrated, not clipped and the slope is not zero), plus sequencing and multiply steps.
// a new sample is accepted only once the last beat has passed to the output register.
// the result sits in an output register; the next sample is taken while it waits.
// if the receiver stalls and a second result is done, the core holds it until the
// register frees, and samples.ready stays low meanwhile.
// reset (rst, synchronous) restores the register defaults, clears the filter seed and
// the clip count and drops any beat in flight.
module ph_probe_conditioner_core
  import ph_pc_pkg::*;
#(
  parameter int SAMPLES_PER_READ = SAMPLES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  ph_pc_chan.sink              samples,
  ph_pc_chan.source            results
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_AVG    = 4'd1;
  localparam logic [3:0] ST_FLT_LD = 4'd2;
  localparam logic [3:0] ST_FLT    = 4'd3;
  localparam logic [3:0] ST_CLIP   = 4'd4;
  localparam logic [3:0] ST_TMP    = 4'd5;
  localparam logic [3:0] ST_SMUL   = 4'd6;
  localparam logic [3:0] ST_SLD    = 4'd7;
  localparam logic [3:0] ST_SDIV   = 4'd8;
  localparam logic [3:0] ST_PMUL   = 4'd9;
  localparam logic [3:0] ST_PLD    = 4'd10;
  localparam logic [3:0] ST_PDIV   = 4'd11;
  localparam logic [3:0] ST_OUT    = 4'd12;

  // configuration registers
  logic                      calibrated;
  logic                      two_point;
  logic signed [SLOPE_W-1:0] slope;
  logic [PH_W-1:0]           offset_ph;
  logic [OFFMV_W-1:0]        offset_mv;

  // sequencer and datapath registers
  logic [3:0]               state;
  logic                     seeded;
  logic [PIN_W-1:0]         filt;
  logic [CNT_W-1:0]         clip_cnt;
  logic [PIN_W-1:0]         avg_q;
  logic                     tvalid_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     fneg;
  logic                     k_neg;
  logic [SLOPE_W-1:0]       k_mag;
  logic [ABSK_W-1:0]        absk;
  logic [DIV_NW-1:0]        prod;
  logic [PNUM_W-1:0]        pnum;
  logic                     dneg;
  logic [PH_W-1:0]          ph_q;
  logic                     ph_ok;
  logic                     comp;
  logic                     clip_q;
  logic                     out_valid;
  result_t                  out_data;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     accept;
  logic                     out_free;
  logic [PROBE_W-1:0]       probe;
  logic                     clip_now;
  logic [PROBE_W:0]         diff;
  logic [PROBE_W-1:0]       dmag;
  logic [PIN_W:0]           fd;
  logic [PIN_W-1:0]         fmag;
  logic [FLT_BITS-1:0]      fnum;
  logic [SLOPE_W-1:0]       slope_mag;
  logic [PIN_W-1:0]         avg_sat;
  logic signed [TK_W-1:0]   t_ext;
  logic signed [TK_W-1:0]   tk;
  logic [PH_BITS-1:0]       pq;
  logic [PH_BITS:0]         ph_sum;
  logic [PH_W-1:0]          ph_neg;
  logic                     pos_ok;
  logic                     neg_ok;
  logic [PH_BITS-1:0]       pden_half;

  assign accept    = samples.valid && samples.ready;
  assign out_free  = !out_valid || results.ready;
  assign probe     = {filt, 1'b0};
  assign clip_now  = filt >= CLIP_Q8;
  assign diff      = {1'b0, probe} - {1'b0, offset_mv};
  assign dmag      = diff[PROBE_W] ? PROBE_W'((PROBE_W+1)'(0) - diff) : diff[PROBE_W-1:0];
  assign fd        = {1'b0, avg_q} - {1'b0, filt};
  assign fmag      = fd[PIN_W] ? PIN_W'((PIN_W+1)'(0) - fd) : fd[PIN_W-1:0];
  assign fnum      = FLT_BITS'(fmag) + FLT_BITS'(fd[PIN_W] ? FLT_RND_NEG : FLT_RND_POS);
  assign slope_mag = slope[SLOPE_W-1] ? SLOPE_W'(0) - SLOPE_W'(slope) : SLOPE_W'(slope);
  assign avg_sat   = (|div_rsp.quot[DIV_NW-1:PIN_W]) ? PIN_MAX : div_rsp.quot[PIN_W-1:0];
  assign t_ext     = temp_q;
  assign tk        = t_ext * TEMP_SCALE + ABS_ZERO;
  assign pq        = div_rsp.quot[PH_BITS-1:0];
  assign ph_sum    = (PH_BITS+1)'(offset_ph) + (PH_BITS+1)'(pq);
  assign ph_neg    = offset_ph - pq[PH_W-1:0];
  assign pos_ok    = ph_sum <= (PH_BITS+1)'(PH_MAX);
  assign neg_ok    = (pq <= PH_BITS'(offset_ph)) && (ph_neg <= PH_MAX);
  assign pden_half = PH_BITS'(k_mag >> 1);

  assign samples.ready = (state == ST_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated <= 1'b0;
      two_point  <= 1'b0;
      slope      <= SLOPE_RST;
      offset_ph  <= OFFSET_PH_RST;
      offset_mv  <= OFFSET_MV_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CALIBRATED: calibrated <= cfg_wdata[0];
        REG_TWO_POINT:  two_point  <= cfg_wdata[0];
        REG_SLOPE:      slope      <= cfg_wdata[SLOPE_W-1:0];
        REG_OFFSET_PH:  offset_ph  <= cfg_wdata[PH_W-1:0];
        REG_OFFSET_MV:  offset_mv  <= cfg_wdata[OFFMV_W-1:0];
        default: ;
      endcase
    end
  end

  // divider requests, numerators left-aligned to the quotient width
  always_comb begin
    div_req = '0;
    case (state)
      ST_IDLE: begin
        div_req.start = accept;
        div_req.num   = {samples.data.adc_sum_mv, {(DIV_NW-SUM_W){1'b0}}};
        div_req.den   = DIV_DW'(SAMPLES_PER_READ);
        div_req.nbits = DIV_CW'(AVG_BITS);
      end
      ST_FLT_LD: begin
        div_req.start = seeded;
        div_req.num   = {fnum, {(DIV_NW-FLT_BITS){1'b0}}};
        div_req.den   = FLT_DEN;
        div_req.nbits = DIV_CW'(FLT_BITS);
      end
      ST_SLD: begin
        div_req.start = 1'b1;
        div_req.num   = prod + SLOPE_HALF;
        div_req.den   = SLOPE_DEN;
        div_req.nbits = DIV_CW'(SLOPE_BITS);
      end
      ST_PLD: begin
        div_req.start = 1'b1;
        div_req.num   = {PH_BITS'(pnum) + pden_half, {(DIV_NW-PH_BITS){1'b0}}};
        div_req.den   = DIV_DW'(k_mag);
        div_req.nbits = DIV_CW'(PH_BITS);
      end
      default: ;
    endcase
  end

  ph_pc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seeded    <= 1'b0;
      filt      <= '0;
      clip_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            state <= ST_FLT_LD;
          end
        end
        ST_FLT_LD: begin
          if (seeded) begin
            state <= ST_FLT;
          end else begin
            filt   <= avg_q;
            seeded <= 1'b1;
            state  <= ST_CLIP;
          end
        end
        ST_FLT: begin
          if (div_rsp.done) begin
            filt  <= fneg ? filt - div_rsp.quot[PIN_W-1:0] : filt + div_rsp.quot[PIN_W-1:0];
            state <= ST_CLIP;
          end
        end
        ST_CLIP: begin
          if (clip_now && (clip_cnt != '1)) begin
            clip_cnt <= clip_cnt + CNT_W'(1);
          end
          if (calibrated && !clip_now) begin
            state <= (!two_point && tvalid_q) ? ST_TMP : ST_PMUL;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_TMP:  state <= ST_SMUL;
        ST_SMUL: state <= ST_SLD;
        ST_SLD:  state <= ST_SDIV;
        ST_SDIV: begin
          if (div_rsp.done) begin
            state <= ST_PMUL;
          end
        end
        ST_PMUL: state <= (k_mag == '0) ? ST_OUT : ST_PLD;
        ST_PLD:  state <= ST_PDIV;
        ST_PDIV: begin
          if (div_rsp.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          tvalid_q <= samples.data.temp_valid;
          temp_q   <= samples.data.temp_sixteenths;
          ph_q     <= '0;
          ph_ok    <= 1'b0;
          comp     <= 1'b0;
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          avg_q <= avg_sat;
        end
      end
      ST_FLT_LD: fneg <= fd[PIN_W];
      ST_CLIP: begin
        clip_q <= clip_now;
        k_mag  <= slope_mag;
        k_neg  <= slope[SLOPE_W-1];
        if (calibrated && !clip_now && !two_point && tvalid_q) begin
          comp <= 1'b1;
        end
      end
      ST_TMP:  absk <= tk[ABSK_W-1:0];
      ST_SMUL: prod <= DIV_NW'(absk) * NOM_SCALE;
      ST_SDIV: begin
        if (div_rsp.done) begin
          k_mag <= div_rsp.quot[SLOPE_W-1:0];
          k_neg <= 1'b1;
        end
      end
      ST_PMUL: begin
        pnum <= PNUM_W'(dmag) * PNUM_W'(MILLI);
        dneg <= diff[PROBE_W] ^ k_neg;
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          ph_ok <= dneg ? neg_ok : pos_ok;
          ph_q  <= (dneg ? neg_ok : pos_ok) ? (dneg ? ph_neg : ph_sum[PH_W-1:0]) : '0;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_data.pin_mv_q8        <= filt;
          out_data.probe_mv_q8      <= probe;
          out_data.clipped          <= clip_q;
          out_data.clip_count       <= clip_cnt;
          out_data.ph_milli         <= ph_q;
          out_data.ph_valid         <= ph_ok;
          out_data.temp_compensated <= comp;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ph_range: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.ph_valid |-> results.data.ph_milli <= PH_MAX)
    else $error("valid pH beyond range");
  a_ph_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.data.ph_valid |-> results.data.ph_milli == '0)
    else $error("invalid pH not zero");
  a_ph_not_clipped: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.ph_valid |-> !results.data.clipped)
    else $error("pH reported on clipped beat");
  a_probe_double: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.data.probe_mv_q8 == {results.data.pin_mv_q8, 1'b0})
    else $error("probe voltage not twice pin voltage");
  a_clip_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLIP |=> $stable(clip_cnt))
    else $error("clip count moved outside clip step");
`endif

endmodule
